[src/frp_pkg.sv]
// Shared types and constants for the FASTA record parser.
package frp_pkg;

    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_AT    = 8'h40;  // '@'
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BASE  = 8'h41;  // 'A', lowest kept body byte

    localparam logic [1:0] EOL_LF   = 2'd0;
    localparam logic [1:0] EOL_CR   = 2'd1;
    localparam logic [1:0] EOL_PAIR = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_MARK,
        PH_HEAD,
        PH_EOL2,
        PH_BODY,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME,
        KIND_BASE,
        KIND_SUMMARY,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic        in_chrom;
        logic [31:0] line_length;
        logic [31:0] record_size;
        logic [31:0] record_start;
        logic [1:0]  eol_kind;
        logic        last;
    } out_beat_t;

    // Results of one input beat, packed from slot 0.
    typedef struct packed {
        logic [1:0] count;
        out_beat_t  slot0;
        out_beat_t  slot1;
    } res_pair_t;

endpackage

[src/frp_core.sv]
// Parser state and per-byte decode; yields up to two results per input beat.
module frp_core
    import frp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_beat_t  beat,
    output res_pair_t res
);

    phase_t      phase_reg, phase_next, phase_mid;
    logic [1:0]  eol_reg, eol_next, eol_mid;
    logic        chrom_reg, chrom_next, chrom_mid;
    logic [31:0] flc_reg, flc_next, flc_mid;
    logic        fld_reg, fld_next, fld_mid;
    logic [31:0] bc_reg, bc_next, bc_mid;
    logic [31:0] bo_reg, bo_next, bo_mid;

    logic [7:0] b;
    logic       is_marker, is_eol, is_base;
    logic       r1_valid, r2_valid;
    out_beat_t  r1, r2, summ_pre, summ_mid, err_beat;

    assign b         = beat.byte_in;
    assign is_marker = (b == CH_GT) || (b == CH_AT);
    assign is_eol    = (b == CH_LF) || (b == CH_CR);
    assign is_base   = (b >= CH_BASE);

    // next state: the byte's effect first, then end of input returns all to reset
    always_comb begin
        phase_mid = phase_reg;
        eol_mid   = eol_reg;
        chrom_mid = chrom_reg;
        flc_mid   = flc_reg;
        fld_mid   = fld_reg;
        bc_mid    = bc_reg;
        bo_mid    = bo_reg;
        unique case (phase_reg)
            PH_MARK: begin
                if (is_marker) begin
                    phase_mid = PH_HEAD;
                    eol_mid   = EOL_LF;
                    chrom_mid = 1'b1;
                    flc_mid   = '0;
                    fld_mid   = 1'b0;
                    bc_mid    = '0;
                end else begin
                    phase_mid = PH_HALT;
                end
            end
            PH_HEAD: begin
                if (is_eol) begin
                    eol_mid   = (b == CH_LF) ? EOL_LF : EOL_CR;
                    phase_mid = PH_EOL2;
                end else if (b == CH_SPACE) begin
                    chrom_mid = 1'b0;
                end
            end
            PH_EOL2, PH_BODY: begin
                phase_mid = PH_BODY;
                if (phase_reg == PH_EOL2 && is_eol) begin
                    eol_mid = EOL_PAIR;
                end else begin
                    if (!fld_reg) begin
                        if (is_marker || is_eol) begin
                            fld_mid = 1'b1;
                        end else begin
                            flc_mid = flc_reg + 32'd1;
                        end
                    end
                    if (is_base) begin
                        bc_mid = bc_reg + 32'd1;
                        bo_mid = bo_reg + 32'd1;
                    end else if (is_marker) begin
                        phase_mid = PH_HEAD;
                        eol_mid   = EOL_LF;
                        chrom_mid = 1'b1;
                        flc_mid   = '0;
                        fld_mid   = 1'b0;
                        bc_mid    = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (beat.end_of_input) begin
            phase_next = PH_MARK;
            eol_next   = EOL_LF;
            chrom_next = 1'b1;
            flc_next   = '0;
            fld_next   = 1'b0;
            bc_next    = '0;
            bo_next    = '0;
        end else begin
            phase_next = phase_mid;
            eol_next   = eol_mid;
            chrom_next = chrom_mid;
            flc_next   = flc_mid;
            fld_next   = fld_mid;
            bc_next    = bc_mid;
            bo_next    = bo_mid;
        end
    end

    // results
    always_comb begin
        err_beat      = '0;
        err_beat.kind = KIND_ERROR;

        summ_pre              = '0;
        summ_pre.kind         = KIND_SUMMARY;
        summ_pre.line_length  = flc_reg;
        summ_pre.record_size  = bc_reg;
        summ_pre.record_start = bo_reg - bc_reg;
        summ_pre.eol_kind     = eol_reg;

        summ_mid              = '0;
        summ_mid.kind         = KIND_SUMMARY;
        summ_mid.line_length  = flc_mid;
        summ_mid.record_size  = bc_mid;
        summ_mid.record_start = bo_mid - bc_mid;
        summ_mid.eol_kind     = eol_mid;

        r1       = '0;
        r1_valid = 1'b0;
        unique case (phase_reg)
            PH_MARK: begin
                if (!is_marker) begin
                    r1_valid = 1'b1;
                    r1       = err_beat;
                end
            end
            PH_HEAD: begin
                if (!is_eol) begin
                    r1_valid      = 1'b1;
                    r1.kind       = KIND_NAME;
                    r1.byte_value = b;
                    r1.in_chrom   = chrom_reg && (b != CH_SPACE);
                end
            end
            PH_EOL2, PH_BODY: begin
                if (!(phase_reg == PH_EOL2 && is_eol)) begin
                    if (is_base) begin
                        r1_valid      = 1'b1;
                        r1.kind       = KIND_BASE;
                        r1.byte_value = b;
                    end else if (is_marker) begin
                        r1_valid = 1'b1;
                        r1       = summ_pre;
                    end
                end
            end
            default: begin
            end
        endcase

        r2       = '0;
        r2_valid = 1'b0;
        if (beat.end_of_input) begin
            if (phase_mid == PH_HEAD) begin
                r2_valid = 1'b1;
                r2       = err_beat;
            end else if (phase_mid == PH_EOL2 || phase_mid == PH_BODY) begin
                r2_valid = 1'b1;
                r2       = summ_mid;
            end
        end
        r2.last = 1'b1;

        res = '0;
        priority if (r1_valid && r2_valid) begin
            res.count = 2'd2;
            res.slot0 = r1;
            res.slot1 = r2;
        end else if (r1_valid) begin
            res.count      = 2'd1;
            res.slot0      = r1;
            res.slot0.last = 1'b1;
        end else if (r2_valid) begin
            res.count = 2'd1;
            res.slot0 = r2;
        end else begin
            res.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MARK;
            eol_reg   <= EOL_LF;
            chrom_reg <= 1'b1;
            flc_reg   <= '0;
            fld_reg   <= 1'b0;
            bc_reg    <= '0;
            bo_reg    <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            eol_reg   <= eol_next;
            chrom_reg <= chrom_next;
            flc_reg   <= flc_next;
            fld_reg   <= fld_next;
            bc_reg    <= bc_next;
            bo_reg    <= bo_next;
        end
    end

endmodule

[src/frp_outq.sv]
// Small result queue: takes up to two beats a cycle, hands out one.
module frp_outq
    import frp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  res_pair_t res,
    output logic      room,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

    out_beat_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]         n_in;
    logic               pop;

    assign n_in       = push ? res.count : 2'd0;
    assign pop        = m_valid && m_ready;
    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);
    assign m_valid    = (cnt_reg != '0);
    assign m_payload  = mem_reg[rd_ptr_reg];
    // room only while at least two slots are free, so an item never has to be split
    assign room       = (cnt_reg <= QCNT_W'(QDEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_in);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(n_in) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res.slot0;
        end
        if (n_in == 2'd2) begin
            mem_reg[wr_ptr_inc] <= res.slot1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/fasta_record_parser_top.sv]
// Top level of the streaming FASTA/FASTQ record parser.
//
//  channel  | dir | ports                          | beat
//  ---------+-----+--------------------------------+------------------------------
//  s_       | in  | s_valid, s_ready, s_payload    | one file byte + end flag
//  m_       | out | m_valid, m_ready, m_payload    | name/base byte, summary, error
//
// One byte is decoded per cycle while s_ready is high, in a single combinational pass
// after the state registers; its results, up to two, are registered into a four-entry
// queue and show on m_ once the beats ahead of them have left. s_ready is high while two
// slots are free, so bytes flow back to back; a two-result byte (only at end of input)
// leaves one extra beat queued, and the input pauses only while more than two beats wait.
// Reset (aresetn low, synchronous) empties the queue and returns to marker search;
// a stalled m_ready backs up into the queue and then holds s_ready low.
module fasta_record_parser_top
    import frp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

    logic      s_fire;
    res_pair_t res;

    assign s_fire = s_valid && s_ready;

    frp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (s_fire),
        .beat    (s_payload),
        .res     (res)
    );

    frp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_fire),
        .res       (res),
        .room      (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
